@@ rtl/core/hmrpc_pkg.sv @@
`timescale 1ns / 1ps
package hmrpc_pkg;

  localparam int CHAN_BITS = 8;
  localparam int HUE_BITS  = 9;
  localparam int IDX_BITS  = 3;
  localparam int MASK_BITS = 7;
  localparam int OUT_CNT_BITS = 21;
  localparam int WIN_BITS  = 50;
  localparam logic [OUT_CNT_BITS-1:0] OUT_CNT_MAX = '1;

  // register indexes of the configuration port
  localparam logic [IDX_BITS-1:0] REG_ACTIVE = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_WIN0   = 3'd1;

  // packed from the least significant bit: hue min first
  typedef struct packed {
    logic [CHAN_BITS-1:0] v_hi;
    logic [CHAN_BITS-1:0] v_lo;
    logic [CHAN_BITS-1:0] s_hi;
    logic [CHAN_BITS-1:0] s_lo;
    logic [HUE_BITS-1:0]  h_hi;
    logic [HUE_BITS-1:0]  h_lo;
  } win_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] hue_raw;
    logic [CHAN_BITS-1:0] saturation;
    logic [CHAN_BITS-1:0] brightness;
    logic                 frame_end;
    logic [MASK_BITS-1:0] match_bits;
    logic [IDX_BITS-1:0]  best_idx;
  } pix_t;

  typedef struct packed {
    logic [MASK_BITS-1:0]    match_bits;
    logic                    frame_done;
    logic                    winner_valid;
    logic [IDX_BITS-1:0]     winner_index;
    logic [OUT_CNT_BITS-1:0] winner_count;
  } res_t;

endpackage

@@ rtl/core/hmrpc_if.sv @@
`timescale 1ns / 1ps
interface hmrpc_in_if;
  import hmrpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CHAN_BITS-1:0] hue_raw;
  logic [CHAN_BITS-1:0] saturation;
  logic [CHAN_BITS-1:0] brightness;
  logic                 frame_end;
  modport source (output valid, hue_raw, saturation, brightness, frame_end, input ready);
  modport sink   (input valid, hue_raw, saturation, brightness, frame_end, output ready);
endinterface

interface hmrpc_out_if;
  import hmrpc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MASK_BITS-1:0]    match_bits;
  logic                    frame_done;
  logic                    winner_valid;
  logic [IDX_BITS-1:0]     winner_index;
  logic [OUT_CNT_BITS-1:0] winner_count;
  modport source (output valid, match_bits, frame_done, winner_valid, winner_index,
                  winner_count, input ready);
  modport sink   (input valid, match_bits, frame_done, winner_valid, winner_index,
                  winner_count, output ready);
endinterface

@@ rtl/core/hsv_multi_range_pixel_classifier.sv @@
`timescale 1ns / 1ps
// Each pixel passes a register in each of the MAX_WINDOWS window cells, then one output register.
// One pixel per clock while not stalled; each cell compares one window and updates its counter.
// Back pressure holds the whole cell row; a two-entry skid buffer keeps in_pix.ready
// registered.
// Reset (synchronous, rst_n low) clears all counters, valid flags and config registers.
module hsv_multi_range_pixel_classifier
  import hmrpc_pkg::*;
#(
  parameter int MAX_WINDOWS = 7,
  parameter int COUNT_BITS  = 21
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hmrpc_in_if.sink             in_pix,
  hmrpc_out_if.source          out_res,
  input  logic                 cfg_we,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [WIN_BITS-1:0]  cfg_data
);

  logic [IDX_BITS-1:0]   active_ranges_r;
  win_t                  win_r [MASK_BITS];
  logic [IDX_BITS-1:0]   n_act;
  logic                  en;

  logic                  stg_valid [MAX_WINDOWS+1];
  pix_t                  stg_pix   [MAX_WINDOWS+1];
  logic [COUNT_BITS-1:0] stg_cnt   [MAX_WINDOWS+1];

  pix_t                  last_pix;
  logic [COUNT_BITS-1:0] last_cnt;
  logic [31:0]           cnt32;
  res_t                  res;
  res_t                  out_data;
  logic                  skid_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_ranges_r <= '0;
      for (int k = 0; k < MASK_BITS; k++) begin
        win_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_ACTIVE) begin
        active_ranges_r <= cfg_data[IDX_BITS-1:0];
      end else begin
        win_r[cfg_index - REG_WIN0] <= cfg_data;
      end
    end
  end

  assign n_act = (active_ranges_r > IDX_BITS'(MAX_WINDOWS)) ?
                 IDX_BITS'(MAX_WINDOWS) : active_ranges_r;

  assign en           = skid_ready;
  assign in_pix.ready = en;

  always_comb begin
    stg_valid[0]             = in_pix.valid;
    stg_pix[0].hue_raw       = in_pix.hue_raw;
    stg_pix[0].saturation    = in_pix.saturation;
    stg_pix[0].brightness    = in_pix.brightness;
    stg_pix[0].frame_end     = in_pix.frame_end;
    stg_pix[0].match_bits    = '0;
    stg_pix[0].best_idx      = '0;
    stg_cnt[0]               = '0;
  end

  for (genvar k = 0; k < MAX_WINDOWS; k++) begin : g_cell
    hmrpc_cell #(
      .COUNT_BITS (COUNT_BITS),
      .IDX        (k)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .en           (en),
      .active       (IDX_BITS'(k) < n_act),
      .win          (win_r[k]),
      .in_valid     (stg_valid[k]),
      .in_pix       (stg_pix[k]),
      .in_best_cnt  (stg_cnt[k]),
      .out_valid    (stg_valid[k+1]),
      .out_pix      (stg_pix[k+1]),
      .out_best_cnt (stg_cnt[k+1])
    );
  end

  assign last_pix = stg_pix[MAX_WINDOWS];
  assign last_cnt = stg_cnt[MAX_WINDOWS];
  assign cnt32    = 32'(last_cnt);

  always_comb begin
    res            = '0;
    res.match_bits = last_pix.match_bits;
    res.frame_done = last_pix.frame_end;
    if (last_pix.frame_end && n_act != '0) begin
      res.winner_valid = 1'b1;
      res.winner_index = last_pix.best_idx;
      res.winner_count = (cnt32 > 32'(OUT_CNT_MAX)) ? OUT_CNT_MAX : cnt32[OUT_CNT_BITS-1:0];
    end
  end

  hmrpc_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stg_valid[MAX_WINDOWS]),
    .in_ready  (skid_ready),
    .in_data   (res),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_data  (out_data)
  );

  assign out_res.match_bits   = out_data.match_bits;
  assign out_res.frame_done   = out_data.frame_done;
  assign out_res.winner_valid = out_data.winner_valid;
  assign out_res.winner_index = out_data.winner_index;
  assign out_res.winner_count = out_data.winner_count;

  a_no_winner_midframe: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.frame_done |-> !out_res.winner_valid &&
    out_res.winner_count == '0) else $error("winner fields set before frame end");

  a_winner_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.winner_valid |-> out_res.winner_index < n_act)
    else $error("winner index outside active windows");

  a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(stg_valid[MAX_WINDOWS])) else $error("cell row moved while stalled");

  a_inactive_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid[MAX_WINDOWS] && n_act == '0 |-> last_pix.match_bits == '0)
    else $error("match reported with no active window");

endmodule

@@ rtl/core/hmrpc_cell.sv @@
`timescale 1ns / 1ps
module hmrpc_cell
  import hmrpc_pkg::*;
#(
  parameter int COUNT_BITS = 21,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  active,
  input  win_t                  win,
  input  logic                  in_valid,
  input  pix_t                  in_pix,
  input  logic [COUNT_BITS-1:0] in_best_cnt,
  output logic                  out_valid,
  output pix_t                  out_pix,
  output logic [COUNT_BITS-1:0] out_best_cnt
);

  logic                  valid_r;
  pix_t                  pix_r;
  logic [COUNT_BITS-1:0] best_cnt_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [HUE_BITS-1:0]   hue2;
  logic                  hit;
  pix_t                  pix_nxt;
  logic [COUNT_BITS-1:0] best_cnt_nxt;

  assign hue2 = {in_pix.hue_raw, 1'b0};

  always_comb begin
    hit = active &&
          win.h_lo <= hue2 && hue2 <= win.h_hi &&
          win.s_lo <= in_pix.saturation && in_pix.saturation <= win.s_hi &&
          win.v_lo <= in_pix.brightness && in_pix.brightness <= win.v_hi;
    // saturate at all ones
    cnt_new = (hit && cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;
    cnt_nxt = in_pix.frame_end ? '0 : cnt_new;

    pix_nxt      = in_pix;
    best_cnt_nxt = in_best_cnt;
    pix_nxt.match_bits[IDX] = hit;
    // first window seeds the running best; later ones replace it only when strictly larger
    if (active && (IDX == 0 || cnt_new > in_best_cnt)) begin
      pix_nxt.best_idx = IDX_BITS'(IDX);
      best_cnt_nxt     = cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (en) begin
      valid_r <= in_valid;
      if (in_valid) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r      <= pix_nxt;
      best_cnt_r <= best_cnt_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_pix      = pix_r;
  assign out_best_cnt = best_cnt_r;

endmodule

@@ rtl/core/hmrpc_skid.sv @@
`timescale 1ns / 1ps
module hmrpc_skid
  import hmrpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  res_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic main_v_r;
  logic spare_v_r;
  res_t main_r;
  res_t spare_r;
  logic pop;
  logic push;

  assign pop      = main_v_r && out_ready;
  assign push     = in_valid && !spare_v_r;
  assign in_ready = !spare_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r  <= 1'b0;
      spare_v_r <= 1'b0;
    end else if (spare_v_r) begin
      if (pop) begin
        main_r    <= spare_r;
        spare_v_r <= 1'b0;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        spare_r   <= in_data;
        spare_v_r <= 1'b1;
      end else begin
        main_r   <= in_data;
        main_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;

  a_spare_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> main_v_r) else $error("skid spare held without main entry");

endmodule
